### rtl/ovle_pkg.sv
// ----------------------------------------------------------------------------
// ovle_pkg
// shared types and constants for the ordered value list engine
// ----------------------------------------------------------------------------
package ovle_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;

    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_EMIT,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [VAL_W-1:0]  item_value;
    } req_word_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [VAL_W-1:0]  entry_value;
        logic [POS_W-1:0]         entry_position;
        logic [COUNT_W-1:0]       entry_count;
        logic                     last;
    } rsp_word_t;

endpackage

### rtl/ordered_value_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_value_list_engine_top
// ordered list of signed values held in a small table, walked by one comparator
// ----------------------------------------------------------------------------
// One request word is taken at a time; req_ready is low until its work is done.
// A single signed comparator and a single registered table read port are stepped
// by the sequencer, one entry per cycle, though a dump holds while the output
// register is full. Sorted insert compares entries until one is greater or equal
// (or the tail is reached), then shifts the entries above that position up;
// append goes straight to the shift at the tail; remove compares until a match,
// then shifts the later entries down, or reports not found. Clear, remove or dump
// on an empty list and append or insert on a full list go straight to the
// response; dump emits one response per entry. Every response waits for the
// output register to be free. A finished response waits in the output register
// while the next request is taken.
module ordered_value_list_engine_top
    import ovle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    logic signed [VAL_W-1:0] mem [CAPACITY];

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] item_reg, item_next;
    logic                    remove_reg, remove_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_word_t               rsp_reg, rsp_next;

    logic                    req_fire;
    logic                    slot_free;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    hit;
    logic [CNT_W-1:0]        cur_plus;
    logic                    dump_last;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // address for the entry needed in the next cycle
    always_comb
    begin
        case (state_next)
            ST_SHIFT_UP:   rd_addr = cur_next - IDX_W'(1);
            ST_SHIFT_DOWN: rd_addr = cur_next + IDX_W'(1);
            default:       rd_addr = cur_next;
        endcase
    end

    // the shared compare unit
    assign hit       = remove_reg ? (item_reg == rd_data_reg) : (item_reg <= rd_data_reg);
    assign cur_plus  = CNT_W'(cur_reg) + CNT_W'(1);
    assign dump_last = (cur_plus == len_reg) || (cur_plus == CNT_W'(MAX_RESULTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        remove_reg <= remove_next;
        stat_reg   <= stat_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        remove_next    = remove_reg;
        stat_next      = stat_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        we             = 1'b0;
        waddr          = cur_reg;
        wdata          = rd_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    item_next   = req.item_value;
                    pos_next    = '0;
                    cur_next    = '0;
                    stat_next   = STAT_OK;
                    remove_next = (req.req_type == REQ_REMOVE);
                    case (req.req_type)
                        REQ_APPEND, REQ_INSERT:
                        begin
                            if (len_reg >= CNT_W'(CAPACITY))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = ST_EMIT;
                            end
                            else if (req.req_type == REQ_APPEND || len_reg == '0)
                            begin
                                cur_next   = IDX_W'(len_reg);
                                pos_next   = IDX_W'(len_reg);
                                state_next = ST_SHIFT_UP;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            len_next   = '0;
                            item_next  = '0;
                            state_next = ST_EMIT;
                        end
                        REQ_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                item_next  = '0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    pos_next   = cur_reg;
                    state_next = remove_reg ? ST_SHIFT_DOWN : ST_SHIFT_UP;
                    if (!remove_reg)
                    begin
                        cur_next = IDX_W'(len_reg);
                    end
                end
                else if (cur_plus == len_reg)
                begin
                    if (remove_reg)
                    begin
                        stat_next  = STAT_NOT_FOUND;
                        pos_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // nothing greater or equal: goes at the tail
                        cur_next   = IDX_W'(len_reg);
                        pos_next   = IDX_W'(len_reg);
                        state_next = ST_SHIFT_UP;
                    end
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end

            ST_SHIFT_UP:
            begin
                we = 1'b1;
                if (cur_reg == pos_reg)
                begin
                    waddr      = pos_reg;
                    wdata      = item_reg;
                    len_next   = len_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    cur_next = cur_reg - IDX_W'(1);
                end
            end

            ST_SHIFT_DOWN:
            begin
                if (cur_plus >= len_reg)
                begin
                    len_next   = len_reg - CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    we       = 1'b1;
                    cur_next = cur_reg + IDX_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_next.status         = stat_reg;
                    rsp_next.entry_value    = item_reg;
                    rsp_next.entry_position = POS_W'(pos_reg);
                    rsp_next.entry_count    = COUNT_W'(len_reg);
                    rsp_next.last           = 1'b1;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                if (slot_free)
                begin
                    rsp_next.status         = STAT_OK;
                    rsp_next.entry_value    = rd_data_reg;
                    rsp_next.entry_position = POS_W'(cur_reg);
                    rsp_next.entry_count    = COUNT_W'(len_reg);
                    rsp_next.last           = dump_last;
                    rsp_valid_next          = 1'b1;
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_full_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_APPEND || req.req_type == REQ_INSERT)
         && len_reg == CNT_W'(CAPACITY))
        |=> (len_reg == CNT_W'(CAPACITY) && state_reg == ST_EMIT))
        else $error("insert into full list changed the list");

    a_shift_up_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_UP) |-> (cur_reg >= pos_reg))
        else $error("shift cursor passed the insertion point");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == REQ_CLEAR) |=> (len_reg == '0))
        else $error("clear left entries in the list");

endmodule
